/* src/dcc_pkg.sv */
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types, constants and the MD4 step function for the DCC hash engine.
// ----------------------------------------------------------------------------
package dcc_pkg;

  typedef logic [3:0][31:0]  md4_state_t;
  typedef logic [15:0][31:0] md4_block_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] K2   = 32'h5a827999;
  localparam logic [31:0] K3   = 32'h6ed9eba1;

  localparam md4_state_t IV_STATE = {IV_D, IV_C, IV_B, IV_A};

  localparam int unsigned STEPS = 48;

  // configuration register indexes
  localparam logic [2:0] REG_SALT_0_1   = 3'd0;
  localparam logic [2:0] REG_SALT_2_3   = 3'd1;
  localparam logic [2:0] REG_SALT_4_5   = 3'd2;
  localparam logic [2:0] REG_SALT_6_7   = 3'd3;
  localparam logic [2:0] REG_SALT_8_9   = 3'd4;
  localparam logic [2:0] REG_SALT_LEN   = 3'd5;
  localparam logic [2:0] REG_TARGET_LO  = 3'd6;
  localparam logic [2:0] REG_TARGET_HI  = 3'd7;

  function automatic logic [3:0] r2_word(input int unsigned k);
    logic [3:0] kk;
    kk = 4'(k);
    return {kk[1:0], kk[3:2]};
  endfunction

  function automatic logic [3:0] r3_word(input int unsigned k);
    logic [3:0] kk;
    kk = 4'(k);
    return {kk[0], kk[1], kk[2], kk[3]};
  endfunction

  // one MD4 step; idx is a constant at each use
  function automatic md4_state_t md4_step(input int unsigned idx, input md4_state_t v,
                                          input md4_block_t m);
    logic [1:0]  p;
    logic [31:0] x, y, z, f, t, sum;
    logic [4:0]  s;
    md4_state_t  r;
    p = 2'(4 - (idx % 4));
    x = v[p + 2'd1];
    y = v[p + 2'd2];
    z = v[p + 2'd3];
    if (idx < 16) begin
      f = (x & y) | (~x & z);
      t = m[4'(idx)];
      case (idx % 4)
        0: s = 5'd3;
        1: s = 5'd7;
        2: s = 5'd11;
        default: s = 5'd19;
      endcase
    end else if (idx < 32) begin
      f = (x & y) | (x & z) | (y & z);
      t = m[r2_word(idx - 16)] + K2;
      case (idx % 4)
        0: s = 5'd3;
        1: s = 5'd5;
        2: s = 5'd9;
        default: s = 5'd13;
      endcase
    end else begin
      f = x ^ y ^ z;
      t = m[r3_word(idx - 32)] + K3;
      case (idx % 4)
        0: s = 5'd3;
        1: s = 5'd9;
        2: s = 5'd11;
        default: s = 5'd15;
      endcase
    end
    sum = v[p] + f + t;
    r = v;
    r[p] = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    return r;
  endfunction

endpackage

/* src/dcc_md4_core.sv */
// ----------------------------------------------------------------------------
// dcc_md4_core
// Fully pipelined MD4 compression: one step per stage, then a feed-forward add.
// ----------------------------------------------------------------------------
module dcc_md4_core import dcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_vld,
  input  md4_block_t in_msg,
  output logic       out_vld,
  output md4_state_t out_dig
);

  md4_state_t st_r  [0:STEPS-1];
  md4_block_t msg_r [0:STEPS-1];
  logic       vld_r [0:STEPS-1];
  md4_state_t dig_r;
  logic       dig_vld_r;

  genvar g;
  generate
    for (g = 0; g < STEPS; g++) begin : g_step
      md4_state_t v_in;
      md4_block_t m_in;
      logic       vi;
      if (g == 0) begin : g_first
        assign v_in = IV_STATE;
        assign m_in = in_msg;
        assign vi   = in_vld;
      end else begin : g_next
        assign v_in = st_r[g-1];
        assign m_in = msg_r[g-1];
        assign vi   = vld_r[g-1];
      end

      // step valid bit
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (en) begin
          vld_r[g] <= vi;
        end
      end

      // step state and message carry
      always_ff @(posedge clk) begin
        if (en) begin
          st_r[g]  <= md4_step(g, v_in, m_in);
          msg_r[g] <= m_in;
        end
      end
    end
  endgenerate

  // feed-forward add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_vld_r <= 1'b0;
    end else if (en) begin
      dig_vld_r <= vld_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dig_r[0] <= st_r[STEPS-1][0] + IV_A;
      dig_r[1] <= st_r[STEPS-1][1] + IV_B;
      dig_r[2] <= st_r[STEPS-1][2] + IV_C;
      dig_r[3] <= st_r[STEPS-1][3] + IV_D;
    end
  end

  assign out_vld = dig_vld_r;
  assign out_dig = dig_r;

endmodule

/* src/dcc_cached_credential_hash.sv */
// ----------------------------------------------------------------------------
// dcc_cached_credential_hash
// Cached credential (DCC v1) hash engine with target compare.
// ----------------------------------------------------------------------------
// Usage:
//   in_* stream: one padded password block per beat (words 0..13 and length).
//   out_* stream: four DCC digest words and a match flag per beat.
//   cfg_*: salt words, salt bit length and target, written while idle.
// From input beat to output beat a result passes two MD4 compressions
// of 48 one-step stages plus a feed-forward add each, then the output register.
// One beat per cycle is taken while the pipeline is not held; each MD4 step has its own stage.
// Reset clears all valid bits and the configuration registers to zero.
// When the receiver stalls, the whole pipeline holds, but it keeps moving
// while its last stage is empty, so in_tready stays high until the result
// reaches the output register and the stage behind it is full too.
// ----------------------------------------------------------------------------
module dcc_cached_credential_hash import dcc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pw_words_0_1 .. pw_words_12_13 (64 each), pw_length (5), zero fill
  input  logic [455:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // dcc_word0 .. dcc_word3 (32 each), match (1), zero fill
  output logic [135:0] out_tdata
);

  logic [4:0][63:0] salt_r;
  logic [31:0]      salt_len_r;
  logic [63:0]      tgt_lo_r, tgt_hi_r;

  logic       en;
  md4_block_t blk1, blk2;
  logic       c1_vld, c2_vld;
  md4_state_t nt_dig, dcc_dig;
  logic       out_vld_r;
  md4_state_t out_dig_r;
  logic       out_match_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      salt_r     <= '0;
      salt_len_r <= '0;
      tgt_lo_r   <= '0;
      tgt_hi_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SALT_0_1:  salt_r[0]  <= cfg_wdata;
        REG_SALT_2_3:  salt_r[1]  <= cfg_wdata;
        REG_SALT_4_5:  salt_r[2]  <= cfg_wdata;
        REG_SALT_6_7:  salt_r[3]  <= cfg_wdata;
        REG_SALT_8_9:  salt_r[4]  <= cfg_wdata;
        REG_SALT_LEN:  salt_len_r <= cfg_wdata[31:0];
        REG_TARGET_LO: tgt_lo_r   <= cfg_wdata;
        REG_TARGET_HI: tgt_hi_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance: output free, or last stage empty
  assign en        = out_tready || !out_vld_r || !c2_vld;
  assign in_tready = en;

  // first block: password words, bit length, zero
  always_comb begin
    blk1        = '0;
    blk1[13:0]  = in_tdata[447:0];
    blk1[14]    = {23'd0, in_tdata[452:448], 4'd0};
    blk1[15]    = '0;
  end

  dcc_md4_core u_nt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid && en),
    .in_msg  (blk1),
    .out_vld (c1_vld),
    .out_dig (nt_dig)
  );

  // second block: nt hash, salt, salt bit length, zero
  always_comb begin
    blk2        = '0;
    blk2[3:0]   = nt_dig;
    blk2[13:4]  = salt_r;
    blk2[14]    = salt_len_r;
    blk2[15]    = '0;
  end

  dcc_md4_core u_dcc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (c1_vld),
    .in_msg  (blk2),
    .out_vld (c2_vld),
    .out_dig (dcc_dig)
  );

  // output register with target compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_tready || !out_vld_r) begin
      out_vld_r <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_vld_r) begin
      out_dig_r   <= dcc_dig;
      out_match_r <= (dcc_dig[1:0] == tgt_lo_r) && (dcc_dig[3:2] == tgt_hi_r);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_match_r, out_dig_r};

endmodule
